FILE: src/ods_pkg.sv
// ----------------------------------------------------------------------------
// ods_pkg
// Shared constants, the arctangent table and control types for the odometry
// relative pose stream.
// ----------------------------------------------------------------------------
package ods_pkg;

  localparam int unsigned CordicStepsDef = 32;
  localparam int unsigned CordicStepsMax = 40;
  localparam int unsigned AtanIdxW       = 6;

  // Four guard bits on top of a 33-bit difference, plus headroom for the
  // quarter turn and the CORDIC gain.
  localparam int unsigned GuardBits = 4;
  localparam int unsigned CordW     = 40;
  localparam int unsigned AngW      = 34;

  // Inverse CORDIC gain in Q0.30.
  localparam int unsigned GainW         = 30;
  localparam logic [GainW-1:0] GainQ30  = 30'd652032874;
  localparam int unsigned MulAW         = 32;
  localparam int unsigned ProdW         = MulAW + GainW;
  localparam int unsigned SumW          = 72;
  localparam int unsigned ScaleShift    = 30 + GuardBits;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctrl_t;

  function automatic logic [31:0] atan_lookup(input logic [AtanIdxW-1:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h2000_0000;
      6'd1:  v = 32'h12E4_051E;
      6'd2:  v = 32'h09FB_385B;
      6'd3:  v = 32'h0511_11D4;
      6'd4:  v = 32'h028B_0D43;
      6'd5:  v = 32'h0145_D7E1;
      6'd6:  v = 32'h00A2_F61E;
      6'd7:  v = 32'h0051_7C55;
      6'd8:  v = 32'h0028_BE53;
      6'd9:  v = 32'h0014_5F2F;
      6'd10: v = 32'h000A_2F98;
      6'd11: v = 32'h0005_17CC;
      6'd12: v = 32'h0002_8BE6;
      6'd13: v = 32'h0001_45F3;
      6'd14: v = 32'h0000_A2FA;
      6'd15: v = 32'h0000_517D;
      6'd16: v = 32'h0000_28BE;
      6'd17: v = 32'h0000_145F;
      6'd18: v = 32'h0000_0A30;
      6'd19: v = 32'h0000_0518;
      6'd20: v = 32'h0000_028C;
      6'd21: v = 32'h0000_0146;
      6'd22: v = 32'h0000_00A3;
      6'd23: v = 32'h0000_0051;
      6'd24: v = 32'h0000_0029;
      6'd25: v = 32'h0000_0014;
      6'd26: v = 32'h0000_000A;
      6'd27: v = 32'h0000_0005;
      6'd28: v = 32'h0000_0003;
      6'd29: v = 32'h0000_0001;
      6'd30: v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

FILE: src/ods_stream_if.sv
// ----------------------------------------------------------------------------
// ods_stream_if
// Valid/ready channels for tracker records in and relative pose items out.
// ----------------------------------------------------------------------------
interface ods_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        time_stamp;
  logic signed [31:0] steer_ticks;
  logic [31:0]        traction_ticks;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_angle;
  logic               first_record;

  modport source (
    output valid, time_stamp, steer_ticks, traction_ticks, pose_x, pose_y,
           pose_angle, first_record,
    input  ready
  );
  modport sink (
    input  valid, time_stamp, steer_ticks, traction_ticks, pose_x, pose_y,
           pose_angle, first_record,
    output ready
  );
endinterface

interface ods_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        time_out;
  logic signed [31:0] steer_ticks_out;
  logic signed [31:0] traction_delta;
  logic signed [31:0] rel_x;
  logic signed [31:0] rel_y;
  logic signed [31:0] rel_angle;

  modport source (
    output valid, time_out, steer_ticks_out, traction_delta, rel_x, rel_y,
           rel_angle,
    input  ready
  );
  modport sink (
    input  valid, time_out, steer_ticks_out, traction_delta, rel_x, rel_y,
           rel_angle,
    output ready
  );
endinterface

FILE: src/ods_cordic.sv
// ----------------------------------------------------------------------------
// ods_cordic
// Rotation-mode CORDIC datapath: one micro-rotation per step, shared adders.
// ----------------------------------------------------------------------------
module ods_cordic #(
  parameter int unsigned CORDIC_STEPS = ods_pkg::CordicStepsDef,
  parameter int unsigned IterW        = $clog2(CORDIC_STEPS)
) (
  input  logic                               clk_i,
  input  ods_pkg::cordic_ctrl_t              ctrl_i,
  input  logic [IterW-1:0]                   idx_i,
  input  logic signed [ods_pkg::CordW-1:0]   x_i,
  input  logic signed [ods_pkg::CordW-1:0]   y_i,
  input  logic signed [ods_pkg::AngW-1:0]    z_i,
  output logic signed [ods_pkg::CordW-1:0]   x_o,
  output logic signed [ods_pkg::CordW-1:0]   y_o
);
  import ods_pkg::*;

  logic signed [CordW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [AngW-1:0]  z_q, z_d, atan_v;

  assign xs     = y_q >>> idx_i;
  assign ys     = x_q >>> idx_i;
  assign atan_v = signed'({2'b00, atan_lookup(AtanIdxW'(idx_i))});

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctrl_i.load) begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (ctrl_i.step) begin
      // Steer toward zero residual angle.
      if (!z_q[AngW-1]) begin
        x_d = x_q - xs;
        y_d = y_q + ys;
        z_d = z_q - atan_v;
      end else begin
        x_d = x_q + xs;
        y_d = y_q - ys;
        z_d = z_q + atan_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

FILE: src/ods_gain_mul.sv
// ----------------------------------------------------------------------------
// ods_gain_mul
// Registered multiplier by the inverse CORDIC gain, used once per half word.
// ----------------------------------------------------------------------------
module ods_gain_mul (
  input  logic                         clk_i,
  input  logic [ods_pkg::MulAW-1:0]    a_i,
  output logic [ods_pkg::ProdW-1:0]    prod_o
);
  import ods_pkg::*;

  logic [ProdW-1:0] prod_q, prod_d;

  assign prod_d = ProdW'(a_i) * ProdW'(GainQ30);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: src/odometry_delta_stream.sv
// ----------------------------------------------------------------------------
// odometry_delta_stream
// Relative planar pose between consecutive tracker records, using an
// iterative CORDIC rotation and a shared gain-correction multiplier.
// ----------------------------------------------------------------------------
//   channel | dir | handshake   | payload
//   in_i    | in  | valid/ready | time, steer, traction, pose x/y/angle, first
//   out_o   | out | valid/ready | time, steer, traction delta, rel x/y/angle
//
// Each item runs through the CORDIC loop, one step per cycle, and then
// through four passes of the gain multiplier before its result is valid.
// in_i.ready is high only while the sequencer is idle; a finished result sits
// in the output register, so a new item can be taken while it waits.
// Reset clears the sequencer, the output valid and the previous-record state.
module odometry_delta_stream #(
  parameter int unsigned CORDIC_STEPS = ods_pkg::CordicStepsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ods_in_if.sink    in_i,
  ods_out_if.source out_o
);
  import ods_pkg::*;

  localparam int unsigned IterW = $clog2(CORDIC_STEPS);
  localparam int unsigned StW   = 2;
  localparam logic [StW-1:0] SIdle = 2'd0;
  localparam logic [StW-1:0] SRot  = 2'd1;
  localparam logic [StW-1:0] SMul  = 2'd2;
  localparam logic [StW-1:0] SDone = 2'd3;

  logic [StW-1:0]   state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic [2:0]       k_q, k_d;
  logic             accept;

  // Previous record.
  logic [31:0] prev_x_q, prev_y_q, prev_h_q, prev_t_q;
  logic        have_prev_q;

  // Item in flight.
  logic [31:0] time_q, steer_q, tdelta_q, ang_q, relx_q, rely_q;
  logic [ProdW-1:0] lo_q;

  // Output register.
  logic        out_valid_q;
  logic [31:0] o_time_q, o_steer_q, o_tdelta_q, o_ang_q, o_relx_q, o_rely_q;

  // Setup of a new item.
  logic              use_cur;
  logic [31:0]       ref_x, ref_y, ref_h, ref_t, a_neg, q_sum, resid;
  logic [32:0]       dx, dy;
  logic [1:0]        quad;
  logic signed [CordW-1:0] x0, y0, x_ld, y_ld, x_cur, y_cur;
  logic signed [AngW-1:0]  z_ld;

  cordic_ctrl_t cctrl;

  assign accept  = in_i.valid && in_i.ready;
  assign use_cur = in_i.first_record || !have_prev_q;

  always_comb begin
    ref_x = use_cur ? in_i.pose_x         : prev_x_q;
    ref_y = use_cur ? in_i.pose_y         : prev_y_q;
    ref_h = use_cur ? in_i.pose_angle     : prev_h_q;
    ref_t = use_cur ? in_i.traction_ticks : prev_t_q;
    dx    = {in_i.pose_x[31], in_i.pose_x} - {ref_x[31], ref_x};
    dy    = {in_i.pose_y[31], in_i.pose_y} - {ref_y[31], ref_y};
    x0    = signed'({{(CordW-33-GuardBits){dx[32]}}, dx, {GuardBits{1'b0}}});
    y0    = signed'({{(CordW-33-GuardBits){dy[32]}}, dy, {GuardBits{1'b0}}});
    // Rotate by minus the previous heading: exact quarter turns first, the
    // residual within an eighth of a turn goes to the CORDIC.
    a_neg = 32'd0 - ref_h;
    q_sum = a_neg + 32'h2000_0000;
    quad  = q_sum[31:30];
    resid = a_neg - {quad, 30'd0};
    z_ld  = signed'({{(AngW-32){resid[31]}}, resid});
    unique case (quad)
      2'd0: begin x_ld = x0;  y_ld = y0;  end
      2'd1: begin x_ld = -y0; y_ld = x0;  end
      2'd2: begin x_ld = -x0; y_ld = -y0; end
      2'd3: begin x_ld = y0;  y_ld = -x0; end
      default: begin x_ld = x0; y_ld = y0; end
    endcase
  end

  assign cctrl.load = accept;
  assign cctrl.step = (state_q == SRot);

  ods_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .IterW        (IterW)
  ) u_cordic (
    .clk_i  (clk_i),
    .ctrl_i (cctrl),
    .idx_i  (iter_q),
    .x_i    (x_ld),
    .y_i    (y_ld),
    .z_i    (z_ld),
    .x_o    (x_cur),
    .y_o    (y_cur)
  );

  // Gain correction: magnitude split into low and high words, each multiplied
  // in turn; the high product is added 32 bits up with rounding.
  logic [CordW-1:0]  mag_sel;
  logic              neg_use;
  logic [MulAW-1:0]  mul_a;
  logic [ProdW-1:0]  prod;
  logic [1:0]        j;
  logic [SumW-1:0]   sum;
  logic [SumW-ScaleShift-1:0] qv;
  logic [31:0]       sat_v;

  assign mag_sel = k_q[1] ? (y_cur[CordW-1] ? CordW'(-y_cur) : CordW'(y_cur))
                          : (x_cur[CordW-1] ? CordW'(-x_cur) : CordW'(x_cur));
  assign mul_a   = k_q[0] ? MulAW'(mag_sel[CordW-1:32]) : mag_sel[31:0];

  ods_gain_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .prod_o (prod)
  );

  assign j       = 2'(k_q - 3'd1);
  assign neg_use = j[1] ? y_cur[CordW-1] : x_cur[CordW-1];
  assign sum     = SumW'({prod, 32'd0}) + SumW'(lo_q) + (SumW'(1) << (ScaleShift - 1));
  assign qv      = sum[SumW-1:ScaleShift];

  always_comb begin
    if (neg_use) begin
      sat_v = (qv > (SumW-ScaleShift)'(32'h8000_0000)) ? 32'h8000_0000
                                                       : 32'd0 - qv[31:0];
    end else begin
      sat_v = (qv > (SumW-ScaleShift)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qv[31:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    k_d     = k_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SRot;
          iter_d  = '0;
        end
      end
      SRot: begin
        if (iter_q == IterW'(CORDIC_STEPS - 1)) begin
          state_d = SMul;
          k_d     = 3'd0;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      SMul: begin
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      iter_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_h_q    <= '0;
      prev_t_q    <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      k_q     <= k_d;
      if (accept) begin
        have_prev_q <= 1'b1;
        prev_x_q    <= in_i.pose_x;
        prev_y_q    <= in_i.pose_y;
        prev_h_q    <= in_i.pose_angle;
        prev_t_q    <= in_i.traction_ticks;
      end
      if (state_q == SDone && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_q   <= in_i.time_stamp;
      steer_q  <= in_i.steer_ticks;
      tdelta_q <= in_i.traction_ticks - ref_t;
      ang_q    <= in_i.pose_angle - ref_h;
    end
    if (state_q == SMul && k_q != 3'd0) begin
      if (!j[0]) begin
        lo_q <= prod;
      end else if (!j[1]) begin
        relx_q <= sat_v;
      end else begin
        rely_q <= sat_v;
      end
    end
    if (state_q == SDone && (!out_valid_q || out_o.ready)) begin
      o_time_q   <= time_q;
      o_steer_q  <= steer_q;
      o_tdelta_q <= tdelta_q;
      o_ang_q    <= ang_q;
      o_relx_q   <= relx_q;
      o_rely_q   <= rely_q;
    end
  end

  assign in_i.ready            = (state_q == SIdle);
  assign out_o.valid           = out_valid_q;
  assign out_o.time_out        = o_time_q;
  assign out_o.steer_ticks_out = signed'(o_steer_q);
  assign out_o.traction_delta  = signed'(o_tdelta_q);
  assign out_o.rel_x           = signed'(o_relx_q);
  assign out_o.rel_y           = signed'(o_rely_q);
  assign out_o.rel_angle       = signed'(o_ang_q);

endmodule

FILE: src/ods_checker.sv
// ----------------------------------------------------------------------------
// ods_checker
// Port-level checks on the relative pose stream, bound to the top level.
// ----------------------------------------------------------------------------
module ods_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] rel_x_i,
  input logic signed [31:0] rel_y_i
);

  // Only one item is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again right after an accepted item");

  // A result never appears the cycle after an item is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result raised too early after acceptance");

  // A fresh result coincides with the sequencer going idle.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result raised while the block is still busy");

  // A stalled result holds its pose.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rel_x_i) && $stable(rel_y_i))
    else $error("stalled result changed or dropped");

endmodule

bind odometry_delta_stream ods_checker u_ods_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .rel_x_i     (out_o.rel_x),
  .rel_y_i     (out_o.rel_y)
);
